// ----- rtl/ghist_pkg.sv -----
// Shared types, constants and helpers of the gray-level histogram core.
// Depends on nothing; every other file of the block uses it.
package ghist_pkg;

   localparam int BIN_BITS   = 8;
   localparam int NUM_BINS   = 2 ** BIN_BITS;
   localparam int COUNT_BITS = 24;
   localparam int OUT_BITS   = 24;
   localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

   typedef logic [BIN_BITS-1:0]   bin_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [OUT_BITS-1:0]   out_count_type;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_COUNT = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef struct packed {
      op_type  op;
      bin_type addr;
   } item_type;

   typedef struct packed {
      logic      rd_en;
      bin_type   rd_addr;
      logic      wr_en;
      bin_type   wr_addr;
      count_type wr_data;
   } ram_req_type;

   typedef struct packed {
      bin_type       index;
      out_count_type count;
   } result_type;

   function automatic out_count_type sat_out(count_type value);
      logic [WIDE_BITS-1:0] wide;
      logic [WIDE_BITS-1:0] limit;
      wide  = WIDE_BITS'(value);
      limit = WIDE_BITS'({OUT_BITS{1'b1}});
      if (wide > limit) begin
         return {OUT_BITS{1'b1}};
      end
      return OUT_BITS'(wide);
   endfunction

endpackage

// ----- rtl/gray_level_histogram_core.sv -----
// Top level of the gray-level histogram: request unpacking, result register
// and the bin store. Depends on ghist_pkg, ghist_bin_ram and ghist_rmw.
//
// The core keeps 256 bins of 24-bit saturating counts in a single-port-write,
// registered-read memory. Each request carries an opcode in req_tuser: clear
// empties every bin at once through per-bin valid flags, count adds one
// to the bin named by the pixel, read returns the bin index and its count;
// the unused opcode is dropped. Unless stalled, one request is taken every
// cycle: the read is issued on acceptance, the update is written back the next
// cycle and the previous write is forwarded so back-to-back counts on one bin
// are exact. Reads go through the request stage and the result register; the
// pipeline stalls only while a read waits for a full result register not taken.
// After reset all bins read as zero at once, with no clearing pass.
module gray_level_histogram_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // pixel [7:0], bin_select [15:8]
   input  logic [1:0]  req_tuser,   // opcode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // bin_index [7:0], bin_count [31:8]
);

   ghist_pkg::item_type    item;
   ghist_pkg::ram_req_type ram_req;
   ghist_pkg::count_type   rd_data;
   ghist_pkg::result_type  result;
   logic                   in_push;
   logic                   in_ready;
   logic                   out_free;
   logic                   out_push;

   logic                   rsp_vld_ff, rsp_vld_in;
   ghist_pkg::result_type  rsp_data_ff, rsp_data_in;

   assign item.op   = ghist_pkg::op_type'(req_tuser);
   assign item.addr = (item.op == ghist_pkg::OP_COUNT) ? req_tdata[7:0] : req_tdata[15:8];

   assign in_push    = req_tvalid && in_ready;
   assign req_tready = in_ready;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   ghist_bin_ram u_bin_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   ghist_rmw u_rmw (
      .clock      (clock),
      .reset      (reset),
      .in_push    (in_push),
      .in_item    (item),
      .in_ready   (in_ready),
      .out_free   (out_free),
      .out_push   (out_push),
      .out_result (result),
      .ram_req    (ram_req),
      .rd_data    (rd_data)
   );

   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (out_push) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_data_ff.count, rsp_data_ff.index};

endmodule

// ----- rtl/ghist_bin_ram.sv -----
// Bin count store: one write port and one registered read port, read-first.
// Depends on ghist_pkg for the bin and count widths.
module ghist_bin_ram (
   input  logic                   clock,
   input  ghist_pkg::ram_req_type ram_req,
   output ghist_pkg::count_type   rd_data
);

   ghist_pkg::count_type mem [ghist_pkg::NUM_BINS];
   ghist_pkg::count_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ghist_rmw.sv -----
// Read-modify-write stage of the histogram: per-bin valid bits, forwarding of
// the last write, saturating increment and read results. Depends on ghist_pkg.
module ghist_rmw (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_push,
   input  ghist_pkg::item_type    in_item,
   output logic                   in_ready,
   input  logic                   out_free,
   output logic                   out_push,
   output ghist_pkg::result_type  out_result,
   output ghist_pkg::ram_req_type ram_req,
   input  ghist_pkg::count_type   rd_data
);

   logic                 s1_vld_ff, s1_vld_in;
   ghist_pkg::item_type  s1_ff, s1_in;
   logic                 fwd_vld_ff, fwd_vld_in;
   ghist_pkg::bin_type   fwd_addr_ff, fwd_addr_in;
   ghist_pkg::count_type fwd_data_ff, fwd_data_in;
   logic [ghist_pkg::NUM_BINS-1:0] valid_ff, valid_in;

   logic                 retire;
   logic                 do_clear;
   logic                 do_count;
   ghist_pkg::count_type old_count;
   ghist_pkg::count_type new_count;

   assign retire   = s1_vld_ff && ((s1_ff.op != ghist_pkg::OP_READ) || out_free);
   assign in_ready = !s1_vld_ff || retire;

   always_comb begin
      do_clear = 1'b0;
      do_count = 1'b0;
      case (s1_ff.op)
         ghist_pkg::OP_CLEAR: do_clear = retire;
         ghist_pkg::OP_COUNT: do_count = retire;
         default: begin
         end
      endcase
   end

   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == s1_ff.addr)) begin
         old_count = fwd_data_ff;
      end else if (valid_ff[s1_ff.addr]) begin
         old_count = rd_data;
      end else begin
         old_count = '0;
      end
      if (old_count == {ghist_pkg::COUNT_BITS{1'b1}}) begin
         new_count = old_count;
      end else begin
         new_count = old_count + ghist_pkg::COUNT_BITS'(1);
      end
   end

   assign ram_req.rd_en   = in_push;
   assign ram_req.rd_addr = in_item.addr;
   assign ram_req.wr_en   = do_count;
   assign ram_req.wr_addr = s1_ff.addr;
   assign ram_req.wr_data = new_count;

   assign out_push         = retire && (s1_ff.op == ghist_pkg::OP_READ);
   assign out_result.index = s1_ff.addr;
   assign out_result.count = ghist_pkg::sat_out(old_count);

   always_comb begin
      s1_vld_in = s1_vld_ff;
      s1_in     = s1_ff;
      if (in_ready) begin
         s1_vld_in = in_push;
         s1_in     = in_item;
      end
   end

   always_comb begin
      fwd_vld_in  = fwd_vld_ff;
      fwd_addr_in = fwd_addr_ff;
      fwd_data_in = fwd_data_ff;
      if (do_clear) begin
         fwd_vld_in = 1'b0;
      end else if (do_count) begin
         fwd_vld_in  = 1'b1;
         fwd_addr_in = s1_ff.addr;
         fwd_data_in = new_count;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (do_clear) begin
         valid_in = '0;
      end else if (do_count) begin
         valid_in[s1_ff.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         fwd_vld_ff <= fwd_vld_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      do_clear |=> !fwd_vld_ff && ($countones(valid_ff) == 0))
      else $error("clear left a bin marked as written");

   a_write_forwarded: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |=> fwd_vld_ff && (fwd_addr_ff == $past(ram_req.wr_addr))
                        && valid_ff[fwd_addr_ff])
      else $error("bin write not captured for forwarding");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !retire) |-> !ram_req.rd_en ##1 (s1_vld_ff && $stable(s1_ff)))
      else $error("stalled request lost or overwritten");

   a_result_from_read: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_free && (s1_ff.op == ghist_pkg::OP_READ))
      else $error("result raised without a read request");

endmodule
